### hw/rtl/twrtc_pkg.sv
// Shared types and constants for the three-wire clock chip serial master.
package twrtc_pkg;

	// Default write buffer depth
	localparam int BUFFER_DEPTH_DEF = 31;

	// Request codes carried by req_type
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// Configuration register byte addresses
	localparam int          CFG_AW        = 3;
	localparam logic [2:0]  CFG_HALF_ADDR = 3'd0;
	localparam logic [7:0]  HALF_RESET    = 8'd5;

	// Command byte fields
	localparam logic [4:0] BURST_ADDR = 5'h1F;
	localparam logic [2:0] LAST_BIT   = 3'd7;

	// Transfer phase, one-hot
	typedef enum logic [5:0] {
		PH_IDLE      = 6'b000001,
		PH_CMD_LOW   = 6'b000010,
		PH_CMD_HIGH  = 6'b000100,
		PH_DATA_LOW  = 6'b001000,
		PH_DATA_HIGH = 6'b010000,
		PH_FINAL     = 6'b100000
	} phase_t;

endpackage

### hw/rtl/three_wire_rtc_serial_master_unit.sv
// Top level: three-wire clock chip serial master with APB setup port.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------------
//   in      | in_valid/in_ready  | req_type buf_index buf_byte is_read to_ram
//           |                    | burst reg_address byte_count io_level
//   out     | out_valid/out_ready| ce_pin sck_pin io_out io_drive read_byte
//           |                    | read_valid read_position last_read busy_res
//   cfg     | psel/penable/pready| paddr pwdata prdata (half_period_ticks at 0x0)
//
// One word is taken per cycle while out_ready keeps up; its result appears in
// the next cycle from the result register, which is the only stage between the two sides.
// in_ready is high whenever the result register is empty or being taken.
// A stalled result holds the block state, so no word is lost or repeated.
// Reset clears all control state and pins (ce, sck, io low, io driven);
// the write buffer is not cleared.
module three_wire_rtc_serial_master_unit #(
	parameter int BUFFER_DEPTH = twrtc_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input words
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [4:0]                  buf_index,
	input  logic [7:0]                  buf_byte,
	input  logic                        is_read,
	input  logic                        to_ram,
	input  logic                        burst,
	input  logic [4:0]                  reg_address,
	input  logic [4:0]                  byte_count,
	input  logic                        io_level,
	// result words
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        ce_pin,
	output logic                        sck_pin,
	output logic                        io_out,
	output logic                        io_drive,
	output logic [7:0]                  read_byte,
	output logic                        read_valid,
	output logic [4:0]                  read_position,
	output logic                        last_read,
	output logic                        busy_res,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [twrtc_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import twrtc_pkg::*;

	localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int EXT_W = (IDX_W >= 5) ? IDX_W + 1 : 6;

	// State
	phase_t      phase_q;
	logic [7:0]  tick_q;
	logic [2:0]  bit_q;
	logic [4:0]  bidx_q;
	logic [4:0]  btot_q;
	logic [7:0]  shift_q;
	logic [7:0]  cmd_q;
	logic        ce_q, sck_q, io_q, drv_q;
	logic [7:0]  half_q;
	logic [7:0]  buf_q [BUFFER_DEPTH];

	// Result register
	logic        out_valid_q;
	logic [7:0]  rd_byte_q;
	logic        rd_valid_q;
	logic [4:0]  rd_pos_q;
	logic        rd_last_q;

	// Next state
	phase_t      n_phase;
	logic [7:0]  n_tick;
	logic [2:0]  n_bit;
	logic [4:0]  n_bidx;
	logic [4:0]  n_btot;
	logic [7:0]  n_shift;
	logic [7:0]  n_cmd;
	logic        n_ce, n_sck, n_io, n_drv;
	logic [7:0]  r_byte;
	logic        r_valid;
	logic [4:0]  r_pos;
	logic        r_last;

	logic        accept;
	logic        cfg_wr;
	logic [8:0]  tick_nx;
	logic [4:0]  bidx_inc;
	logic [4:0]  fetch_sel;
	logic [EXT_W-1:0] fetch_ext;
	logic [EXT_W-1:0] load_ext;
	logic [7:0]  fetch_byte;
	logic        load_hit;
	logic [4:0]  start_addr;
	logic [7:0]  sample_byte;
	logic [2:0]  bit_inc;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// APB register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == CFG_HALF_ADDR) ? {24'd0, half_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
		end else if (cfg_wr && paddr == CFG_HALF_ADDR) begin
			half_q <= pwdata[7:0];
		end
	end

	// Write buffer load and fetch
	assign load_ext  = EXT_W'(buf_index);
	assign load_hit  = load_ext < EXT_W'(BUFFER_DEPTH);
	assign bidx_inc  = bidx_q + 5'd1;
	assign fetch_sel = (phase_q == PH_CMD_HIGH) ? 5'd0 : bidx_inc;
	assign fetch_ext = EXT_W'(fetch_sel);
	assign fetch_byte = (fetch_ext < EXT_W'(BUFFER_DEPTH)) ?
		buf_q[fetch_ext[IDX_W-1:0]] : 8'd0;

	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_LOAD && load_hit) begin
			buf_q[load_ext[IDX_W-1:0]] <= buf_byte;
		end
	end

	assign tick_nx    = {1'b0, tick_q} + 9'd1;
	assign start_addr = burst ? BURST_ADDR : reg_address;
	assign bit_inc    = bit_q + 3'd1;
	assign sample_byte = shift_q | ({7'd0, io_level} << bit_q);

	// Advance the transfer for one word
	always_comb begin
		n_phase = phase_q;
		n_tick  = tick_q;
		n_bit   = bit_q;
		n_bidx  = bidx_q;
		n_btot  = btot_q;
		n_shift = shift_q;
		n_cmd   = cmd_q;
		n_ce    = ce_q;
		n_sck   = sck_q;
		n_io    = io_q;
		n_drv   = drv_q;
		r_byte  = 8'd0;
		r_valid = 1'b0;
		r_pos   = 5'd0;
		r_last  = 1'b0;
		case (req_type)
			REQ_START: begin
				if (phase_q == PH_IDLE) begin
					n_cmd   = {1'b1, to_ram, start_addr, is_read};
					n_btot  = byte_count;
					n_bidx  = 5'd0;
					n_bit   = 3'd0;
					n_tick  = 8'd0;
					n_ce    = 1'b1;
					n_sck   = 1'b0;
					n_drv   = 1'b1;
					n_io    = is_read;
					n_phase = PH_CMD_LOW;
				end
			end
			REQ_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (tick_nx < {1'b0, half_q}) begin
						n_tick = tick_nx[7:0];
					end else begin
						n_tick = 8'd0;
						case (phase_q)
							PH_CMD_LOW: begin
								n_sck   = 1'b1;
								n_phase = PH_CMD_HIGH;
							end
							PH_CMD_HIGH: begin
								if (bit_q == LAST_BIT) begin
									if (cmd_q[0]) begin
										n_io  = 1'b0;
										n_drv = 1'b0;
									end
									n_bidx = 5'd0;
									if (btot_q == 5'd0) begin
										n_ce    = 1'b0;
										n_phase = PH_FINAL;
									end else begin
										// enter first data bit
										n_phase = PH_DATA_LOW;
										n_sck   = 1'b0;
										n_bit   = 3'd0;
										if (cmd_q[0]) begin
											n_shift = 8'd0;
										end else begin
											n_shift = fetch_byte;
											n_io    = fetch_byte[0];
										end
									end
								end else begin
									n_bit   = bit_inc;
									n_sck   = 1'b0;
									n_io    = cmd_q[bit_inc];
									n_phase = PH_CMD_LOW;
								end
							end
							PH_DATA_LOW: begin
								if (cmd_q[0]) begin
									n_shift = sample_byte;
									if (bit_q == LAST_BIT) begin
										r_valid = 1'b1;
										r_byte  = sample_byte;
										r_pos   = bidx_q;
										r_last  = ({1'b0, bidx_q} + 6'd1) == {1'b0, btot_q};
									end
								end
								n_sck   = 1'b1;
								n_phase = PH_DATA_HIGH;
							end
							PH_DATA_HIGH: begin
								if (bit_q == LAST_BIT) begin
									n_bidx = bidx_inc;
									if (bidx_inc >= btot_q) begin
										n_ce    = 1'b0;
										n_phase = PH_FINAL;
									end else begin
										// enter next data byte
										n_phase = PH_DATA_LOW;
										n_sck   = 1'b0;
										n_bit   = 3'd0;
										if (cmd_q[0]) begin
											n_shift = 8'd0;
										end else begin
											n_shift = fetch_byte;
											n_io    = fetch_byte[0];
										end
									end
								end else begin
									n_bit = bit_inc;
									n_sck = 1'b0;
									if (!cmd_q[0]) begin
										n_io = shift_q[bit_inc];
									end
									n_phase = PH_DATA_LOW;
								end
							end
							default: begin
								n_phase = PH_IDLE;
							end
						endcase
					end
				end
			end
			default: begin
				// buffer loads and unused codes leave the transfer alone
			end
		endcase
	end

	// Register state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= 8'd0;
			bit_q   <= 3'd0;
			bidx_q  <= 5'd0;
			btot_q  <= 5'd0;
			shift_q <= 8'd0;
			cmd_q   <= 8'd0;
			ce_q    <= 1'b0;
			sck_q   <= 1'b0;
			io_q    <= 1'b0;
			drv_q   <= 1'b1;
		end else if (accept) begin
			phase_q <= n_phase;
			tick_q  <= n_tick;
			bit_q   <= n_bit;
			bidx_q  <= n_bidx;
			btot_q  <= n_btot;
			shift_q <= n_shift;
			cmd_q   <= n_cmd;
			ce_q    <= n_ce;
			sck_q   <= n_sck;
			io_q    <= n_io;
			drv_q   <= n_drv;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_byte_q  <= r_byte;
			rd_valid_q <= r_valid;
			rd_pos_q   <= r_pos;
			rd_last_q  <= r_last;
		end
	end

	// Pins follow the state, which only moves together with the result
	assign out_valid     = out_valid_q;
	assign ce_pin        = ce_q;
	assign sck_pin       = sck_q;
	assign io_out        = io_q;
	assign io_drive      = drv_q;
	assign busy_res      = (phase_q != PH_IDLE);
	assign read_byte     = rd_byte_q;
	assign read_valid    = rd_valid_q;
	assign read_position = rd_pos_q;
	assign last_read     = rd_last_q;

endmodule

### hw/rtl/twrtc_checker.sv
// Port-level checker for the serial master, bound to the top level.
module twrtc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       ce_pin,
	input logic       io_drive,
	input logic [7:0] read_byte,
	input logic       read_valid,
	input logic [4:0] read_position,
	input logic       last_read,
	input logic       busy_res
);

	// Chip enable only while a transfer runs
	a_ce_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_res |-> !ce_pin)
		else $error("chip enable high while idle");

	// A completed read byte comes with the chip selected and IO released
	a_read_bus: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> ce_pin && busy_res && !io_drive)
		else $error("read byte outside a selected read");

	// Read fields are zero when no byte completes
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> read_byte == 8'd0 && read_position == 5'd0
			&& !last_read)
		else $error("read fields set without a read byte");

	// A stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_byte)
			&& $stable(ce_pin))
		else $error("result changed while stalled");

endmodule

bind three_wire_rtc_serial_master_unit twrtc_checker u_twrtc_checker (.*);
